// ----- sv/tlrl_pkg.sv -----
// Package for the two-level token bucket limiter.
// Holds sizes, configuration register indexes and the client entry type.
// No dependencies.
package tlrl_pkg;

  localparam int unsigned CLIENT_SLOTS = 256;
  localparam int unsigned SLOT_W = $clog2(CLIENT_SLOTS);

  localparam int unsigned TOK_W = 36;
  localparam int unsigned RATE_W = 20;
  localparam int unsigned MS_W = 48;
  localparam int unsigned WALL_W = 40;
  localparam int unsigned SEC_W = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [TOK_W-1:0] UNITS_PER_TOKEN = 36'd60000;

  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_RATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDLE = 3'd3;

  typedef struct packed {
    logic [TOK_W-1:0]  tokens;
    logic [RATE_W-1:0] rate;
    logic [MS_W-1:0]   last_ms;
  } entry_t;

endpackage

// ----- sv/tlrl_if.sv -----
// Request and response channel interfaces of the token bucket limiter.
// Depends on tlrl_pkg.
interface tlrl_req_if import tlrl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [7:0]          client_slot;
  logic [RATE_W-1:0]   endpoint_rpm;
  logic [MS_W-1:0]     now_ms;
  logic [WALL_W-1:0]   wall_s;

  modport source (output valid, client_slot, endpoint_rpm, now_ms, wall_s, input ready);
  modport sink (input valid, client_slot, endpoint_rpm, now_ms, wall_s, output ready);
endinterface

interface tlrl_rsp_if import tlrl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                allowed;
  logic [RATE_W-1:0]   limit_rpm;
  logic [RATE_W-1:0]   remaining;
  logic [5:0]          retry_after_s;
  logic [WALL_W:0]     reset_epoch_s;

  modport source (output valid, allowed, limit_rpm, remaining, retry_after_s, reset_epoch_s,
                  input ready);
  modport sink (input valid, allowed, limit_rpm, remaining, retry_after_s, reset_epoch_s,
                output ready);
endinterface

// ----- sv/tlrl_mul.sv -----
// Shared registered multiplier of the limiter datapath.
// Depends on tlrl_pkg.
module tlrl_mul import tlrl_pkg::*; (
  input  logic              clk_i,
  input  logic [RATE_W-1:0] a_i,
  input  logic [SEC_W-1:0]  b_i,
  output logic [36:0]       p_o
);
  logic [36:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 37'(a_i) * 37'(b_i);
  end

  assign p_o = p_q;
endmodule

// ----- sv/tlrl_entry_ram.sv -----
// Client entry table: one write port, one registered read port.
// Depends on tlrl_pkg.
module tlrl_entry_ram import tlrl_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [SLOT_W-1:0] waddr_i,
  input  entry_t            wdata_i,
  input  logic [SLOT_W-1:0] raddr_i,
  output entry_t            rdata_o
);
  entry_t mem [CLIENT_SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- sv/tlrl_core.sv -----
// Sequencer of the limiter: sweep, global and client refill, retry and quotient steps.
// Depends on tlrl_pkg, tlrl_if, tlrl_mul and tlrl_entry_ram.
module tlrl_core import tlrl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tlrl_req_if.sink              req,
  tlrl_rsp_if.source            rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  typedef enum logic [4:0] {
    ST_IDLE, ST_SW_MUL, ST_SW_CMP, ST_SW_LIM, ST_SW_RD, ST_SW_CHK,
    ST_CAP, ST_ADD, ST_SUM, ST_GCHK, ST_CRD, ST_NEW, ST_CCHK,
    ST_RDEN, ST_RINIT, ST_RLOOP, ST_DIV, ST_OUT
  } state_e;

  // One token is 32 * 1875 units; the quotient by 1875 uses a 42-bit scaled reciprocal.
  localparam logic [31:0] RECIP_1875 = 32'd2345624806;

  state_e state_q;

  logic [RATE_W-1:0] grate_q, drate_q;
  logic [SEC_W-1:0]  sweep_s_q, idle_s_q;
  logic [TOK_W-1:0]  gtok_q;
  logic [MS_W-1:0]   glast_q, sweep_last_q;
  logic [CLIENT_SLOTS-1:0] valid_q;

  logic [SLOT_W-1:0] slot_q, idx_q;
  logic [RATE_W-1:0] eff_q, rate_q;
  logic [MS_W-1:0]   now_q, last_q;
  logic [WALL_W-1:0] wall_q;
  logic [TOK_W-1:0]  tok_q, cap_q, rem_q;
  logic [15:0]       el_q, need_q;
  logic              el_big_q, client_q;
  logic [26:0]       idle_lim_q;
  logic [29:0]       den_q;
  logic [30:0]       acc_q;
  logic [5:0]        cnt_q;

  logic              res_allowed_q;
  logic [RATE_W-1:0] res_limit_q, res_rem_q;
  logic [5:0]        res_retry_q;

  logic              out_valid_q, out_allowed_q;
  logic [RATE_W-1:0] out_limit_q, out_rem_q;
  logic [5:0]        out_retry_q;
  logic [WALL_W:0]   out_epoch_q;

  logic [RATE_W-1:0] mul_a;
  logic [SEC_W-1:0]  mul_b;
  logic [36:0]       prod;

  logic              ram_we;
  entry_t            ram_wdata, ram_rdata;
  logic [SLOT_W-1:0] ram_raddr;

  logic [MS_W-1:0]   el_full, sw_gap, idle_gap;
  logic [TOK_W-1:0]  add_v, full_v, new_tok, cli_tok;
  logic [TOK_W:0]    sum_v;
  logic [62:0]       quot_prod;

  tlrl_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  tlrl_entry_ram u_ram (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(slot_q), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SW_MUL: begin mul_a = RATE_W'(sweep_s_q); mul_b = 17'd1000; end
      ST_SW_CMP: begin mul_a = RATE_W'(idle_s_q); mul_b = 17'd1000; end
      ST_CAP:    begin mul_a = rate_q; mul_b = 17'd60000; end
      ST_ADD:    begin mul_a = rate_q; mul_b = SEC_W'(el_q); end
      ST_CRD:    begin mul_a = eff_q; mul_b = 17'd60000; end
      ST_RDEN:   begin mul_a = rate_q; mul_b = 17'd1000; end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign el_full  = (now_q > last_q) ? now_q - last_q : '0;
  assign sw_gap   = now_q - sweep_last_q;
  assign idle_gap = now_q - ram_rdata.last_ms;
  assign add_v    = el_big_q ? cap_q : prod[TOK_W-1:0];
  assign sum_v    = {1'b0, tok_q} + {1'b0, add_v};
  assign full_v   = prod[TOK_W-1:0];
  assign new_tok  = (full_v >= UNITS_PER_TOKEN) ? full_v - UNITS_PER_TOKEN : '0;
  assign cli_tok  = (tok_q < UNITS_PER_TOKEN) ? tok_q : tok_q - UNITS_PER_TOKEN;
  assign quot_prod = 63'(rem_q[TOK_W-1:5]) * 63'(RECIP_1875);

  assign ram_raddr = (state_q == ST_SW_RD) ? idx_q : slot_q;
  assign ram_we    = (state_q == ST_NEW) || (state_q == ST_CCHK);
  always_comb begin
    ram_wdata.last_ms = now_q;
    if (state_q == ST_NEW) begin
      ram_wdata.tokens = new_tok;
      ram_wdata.rate   = eff_q;
    end else begin
      ram_wdata.tokens = cli_tok;
      ram_wdata.rate   = rate_q;
    end
  end

  assign req.ready         = (state_q == ST_IDLE);
  assign rsp.valid         = out_valid_q;
  assign rsp.allowed       = out_allowed_q;
  assign rsp.limit_rpm     = out_limit_q;
  assign rsp.remaining     = out_rem_q;
  assign rsp.retry_after_s = out_retry_q;
  assign rsp.reset_epoch_s = out_epoch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      grate_q       <= 20'd600;
      drate_q       <= 20'd60;
      sweep_s_q     <= 17'd300;
      idle_s_q      <= 17'd600;
      gtok_q        <= 36'd36000000;
      glast_q       <= '0;
      sweep_last_q  <= '0;
      valid_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GLOBAL_RATE:    grate_q <= cfg_data_i;
          CFG_DEFAULT_RATE:   drate_q <= cfg_data_i;
          CFG_SWEEP_INTERVAL: sweep_s_q <= cfg_data_i[SEC_W-1:0];
          CFG_MAX_IDLE:       idle_s_q <= cfg_data_i[SEC_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && rsp.ready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req.valid) begin
            slot_q  <= req.client_slot[SLOT_W-1:0];
            eff_q   <= (req.endpoint_rpm != '0) ? req.endpoint_rpm : drate_q;
            now_q   <= req.now_ms;
            wall_q  <= req.wall_s;
            state_q <= ST_SW_MUL;
          end
        end
        ST_SW_MUL: begin
          tok_q    <= gtok_q;
          last_q   <= glast_q;
          rate_q   <= grate_q;
          client_q <= 1'b0;
          state_q  <= ST_SW_CMP;
        end
        ST_SW_CMP: begin
          if (now_q >= sweep_last_q && sw_gap >= MS_W'(prod)) begin
            sweep_last_q <= now_q;
            state_q      <= ST_SW_LIM;
          end else begin
            state_q <= ST_CAP;
          end
        end
        ST_SW_LIM: begin
          idle_lim_q <= prod[26:0];
          idx_q      <= '0;
          state_q    <= ST_SW_RD;
        end
        ST_SW_RD: state_q <= ST_SW_CHK;
        ST_SW_CHK: begin
          if (now_q > ram_rdata.last_ms && idle_gap > MS_W'(idle_lim_q)) begin
            valid_q[idx_q] <= 1'b0;
          end
          idx_q   <= idx_q + 1'b1;
          state_q <= (idx_q == SLOT_W'(CLIENT_SLOTS - 1)) ? ST_CAP : ST_SW_RD;
        end
        ST_CAP: begin
          el_q     <= el_full[15:0];
          el_big_q <= (el_full >= MS_W'(UNITS_PER_TOKEN));
          state_q  <= ST_ADD;
        end
        ST_ADD: begin
          cap_q   <= prod[TOK_W-1:0];
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          tok_q   <= (sum_v < {1'b0, cap_q}) ? sum_v[TOK_W-1:0] : cap_q;
          state_q <= client_q ? ST_CCHK : ST_GCHK;
        end
        ST_GCHK: begin
          glast_q <= now_q;
          if (tok_q < UNITS_PER_TOKEN) begin
            gtok_q        <= tok_q;
            res_allowed_q <= 1'b0;
            res_limit_q   <= grate_q;
            res_rem_q     <= '0;
            state_q       <= ST_RDEN;
          end else begin
            gtok_q  <= tok_q - UNITS_PER_TOKEN;
            state_q <= ST_CRD;
          end
        end
        ST_CRD: begin
          if (valid_q[slot_q]) begin
            tok_q    <= ram_rdata.tokens;
            rate_q   <= ram_rdata.rate;
            last_q   <= ram_rdata.last_ms;
            client_q <= 1'b1;
            state_q  <= ST_CAP;
          end else begin
            state_q <= ST_NEW;
          end
        end
        ST_NEW: begin
          valid_q[slot_q] <= 1'b1;
          res_allowed_q   <= 1'b1;
          res_limit_q     <= eff_q;
          res_retry_q     <= '0;
          rem_q           <= new_tok;
          state_q         <= ST_DIV;
        end
        ST_CCHK: begin
          res_limit_q <= eff_q;
          if (tok_q < UNITS_PER_TOKEN) begin
            res_allowed_q <= 1'b0;
            res_rem_q     <= '0;
            state_q       <= ST_RDEN;
          end else begin
            res_allowed_q <= 1'b1;
            res_retry_q   <= '0;
            rem_q         <= cli_tok;
            state_q       <= ST_DIV;
          end
        end
        ST_RDEN: begin
          if (rate_q == '0) begin
            res_retry_q <= 6'd1;
            state_q     <= ST_OUT;
          end else begin
            state_q <= ST_RINIT;
          end
        end
        ST_RINIT: begin
          den_q   <= prod[29:0];
          need_q  <= 16'(UNITS_PER_TOKEN - tok_q);
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= ST_RLOOP;
        end
        ST_RLOOP: begin
          if (acc_q >= 31'(need_q)) begin
            res_retry_q <= cnt_q;
            state_q     <= ST_OUT;
          end else begin
            acc_q <= acc_q + 31'(den_q);
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DIV: begin
          res_rem_q <= quot_prod[61:42];
          state_q   <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || rsp.ready) begin
            out_valid_q   <= 1'b1;
            out_allowed_q <= res_allowed_q;
            out_limit_q   <= res_limit_q;
            out_rem_q     <= res_rem_q;
            out_retry_q   <= res_retry_q;
            out_epoch_q   <= {1'b0, wall_q} +
                             (res_allowed_q ? 41'd60 : (WALL_W + 1)'(res_retry_q));
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/two_level_token_bucket_limiter.sv -----
// Two-level token bucket limiter: one request in, one decision out.
// A new client, a known client and a global or client denial take different paths; a denial also
// works out its retry time in a loop that counts seconds.
// A sweep checks every entry; the next request is taken in the cycle after the decision registers.
// Reset is asynchronous: registers take their defaults, the global bucket is full, entries invalid.
module two_level_token_bucket_limiter import tlrl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tlrl_req_if.sink              req,
  tlrl_rsp_if.source            rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  tlrl_core u_core (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );
endmodule

// ----- sv/tlrl_checker.sv -----
// Port-level checks of the limiter, bound to the top level.
// Depends on tlrl_pkg and two_level_token_bucket_limiter.
module tlrl_checker import tlrl_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              allowed,
  input logic [RATE_W-1:0] remaining,
  input logic [5:0]        retry
);
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("ready right after a transaction");

  a_allowed_no_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && allowed |-> retry == 6'd0) else $error("retry on allowed result");

  a_denied_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !allowed |-> remaining == '0 && retry >= 6'd1 && retry <= 6'd60)
    else $error("bad denied result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(allowed))
    else $error("result dropped while stalled");
endmodule

bind two_level_token_bucket_limiter tlrl_checker u_tlrl_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .allowed(rsp.allowed),
  .remaining(rsp.remaining), .retry(rsp.retry_after_s)
);

// ----- test/tlrl_tb_pkg.sv -----
// Request and response record types used by the limiter testbench.
// Depends on tlrl_pkg.
package tlrl_tb_pkg;
  import tlrl_pkg::*;

  typedef struct packed {
    logic [7:0]        client_slot;
    logic [RATE_W-1:0] endpoint_rpm;
    logic [MS_W-1:0]   now_ms;
    logic [WALL_W-1:0] wall_s;
  } request_t;

  typedef struct packed {
    logic              allowed;
    logic [RATE_W-1:0] limit_rpm;
    logic [RATE_W-1:0] remaining;
    logic [5:0]        retry_after_s;
    logic [WALL_W:0]   reset_epoch_s;
  } decision_t;
endpackage

// ----- test/tb_top.sv -----
// Testbench for the two-level token bucket limiter: a directed table, then random requests.
// Every decision is compared with a behavioral bucket model kept inside this module.
// Depends on tlrl_pkg, tlrl_tb_pkg, the request and response interfaces and two_level_token_bucket_limiter.
module tb_top import tlrl_pkg::*, tlrl_tb_pkg::*; ();

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 700;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [63:0] UNITS = 64'd60000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  tlrl_req_if req ();
  tlrl_rsp_if rsp ();

  two_level_token_bucket_limiter dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req.sink), .rsp(rsp.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  logic [63:0] global_rate, default_rate, sweep_s, idle_s;
  logic [63:0] global_tokens, global_last, last_sweep;
  logic        slot_valid [CLIENT_SLOTS];
  logic [63:0] slot_tokens [CLIENT_SLOTS];
  logic [63:0] slot_rate [CLIENT_SLOTS];
  logic [63:0] slot_last [CLIENT_SLOTS];

  decision_t pending_decisions [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_rsp = 1'b0;
  bit pressure_go = 1'b0;
  logic [63:0] clock_ms = 0;
  logic [63:0] clock_wall = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] refilled(logic [63:0] tok, logic [63:0] last,
                                           logic [63:0] now, logic [63:0] rate);
    logic [63:0] cap, gap, add;
    cap = rate * UNITS;
    gap = (now > last) ? now - last : 64'd0;
    add = (gap >= UNITS) ? cap : gap * rate;
    return (tok + add < cap) ? tok + add : cap;
  endfunction

  function automatic logic [63:0] wait_seconds(logic [63:0] tok, logic [63:0] rate);
    logic [63:0] s;
    if (tok >= UNITS || rate == 0) begin
      s = 0;
    end else begin
      s = (UNITS - tok + rate * 1000 - 1) / (rate * 1000);
    end
    return (s < 1) ? 64'd1 : s;
  endfunction

  function automatic decision_t denial(logic [63:0] rate, logic [63:0] secs,
                                       logic [63:0] wall);
    decision_t d;
    d.allowed = 1'b0;
    d.limit_rpm = rate[RATE_W-1:0];
    d.remaining = '0;
    d.retry_after_s = secs[5:0];
    d.reset_epoch_s = 41'(wall + secs);
    return d;
  endfunction

  function automatic decision_t decide(request_t r);
    logic [63:0] now, wall, eff, lim;
    int s;
    decision_t d;
    s = r.client_slot;
    now = r.now_ms;
    wall = r.wall_s;
    eff = (r.endpoint_rpm != 0) ? 64'(r.endpoint_rpm) : default_rate;
    if (now >= last_sweep && now - last_sweep >= sweep_s * 1000) begin
      lim = idle_s * 1000;
      last_sweep = now;
      for (int i = 0; i < CLIENT_SLOTS; i++) begin
        if (slot_valid[i] && now > slot_last[i] && now - slot_last[i] > lim) begin
          slot_valid[i] = 1'b0;
        end
      end
    end
    global_tokens = refilled(global_tokens, global_last, now, global_rate);
    global_last = now;
    if (global_tokens < UNITS) begin
      return denial(global_rate, wait_seconds(global_tokens, global_rate), wall);
    end
    global_tokens -= UNITS;
    if (!slot_valid[s]) begin
      slot_valid[s] = 1'b1;
      slot_rate[s] = eff;
      slot_tokens[s] = (eff * UNITS >= UNITS) ? eff * UNITS - UNITS : 64'd0;
      slot_last[s] = now;
    end else begin
      slot_tokens[s] = refilled(slot_tokens[s], slot_last[s], now, slot_rate[s]);
      slot_last[s] = now;
      if (slot_tokens[s] < UNITS) begin
        return denial(eff, wait_seconds(slot_tokens[s], slot_rate[s]), wall);
      end
      slot_tokens[s] -= UNITS;
    end
    d.allowed = 1'b1;
    d.limit_rpm = eff[RATE_W-1:0];
    d.remaining = RATE_W'(slot_tokens[s] / UNITS);
    d.retry_after_s = '0;
    d.reset_epoch_s = 41'(wall + 60);
    return d;
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    logic [63:0] v;
    v = (idx >= CFG_SWEEP_INTERVAL) ? (value & 64'h1FFFF) : (value & 64'hFFFFF);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GLOBAL_RATE: global_rate = v;
      CFG_DEFAULT_RATE: default_rate = v;
      CFG_SWEEP_INTERVAL: sweep_s = v;
      CFG_MAX_IDLE: idle_s = v;
      default: ;
    endcase
  endtask

  task automatic quiesce();
    req.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // The request stays valid across back-to-back transactions without a low pulse when send_idle_pct is zero.
  task automatic send_request(request_t r, bit typed, decision_t want);
    decision_t d;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.client_slot <= r.client_slot;
    req.endpoint_rpm <= r.endpoint_rpm;
    req.now_ms <= r.now_ms;
    req.wall_s <= r.wall_s;
    d = decide(r);
    if (typed && d != want) begin
      $error("directed row disagrees with bucket model");
      errors++;
    end
    pending_decisions = {pending_decisions, d};
    do @(posedge clk_i); while (!req.ready);
  endtask

  function automatic request_t next_request(int slot_hi, int rpm_kind);
    request_t r;
    clock_ms += $urandom_range(3) == 0 ? $urandom_range(200000) : $urandom_range(400);
    if ($urandom_range(40) == 0) clock_ms -= $urandom_range(5000);
    clock_wall += $urandom_range(2);
    r.client_slot = 8'($urandom_range(slot_hi));
    case (rpm_kind)
      0: r.endpoint_rpm = 0;
      1: r.endpoint_rpm = RATE_W'($urandom_range(20, 1));
      default: r.endpoint_rpm = RATE_W'($urandom);
    endcase
    r.now_ms = clock_ms[MS_W-1:0];
    r.wall_s = clock_wall[WALL_W-1:0];
    return r;
  endfunction

  task automatic run_phase(int n, int idle_pct, int stall_pct, int slot_hi, int kind);
    request_t r;
    decision_t none;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    none = '0;
    for (int i = 0; i < n; i++) begin
      r = next_request(slot_hi, (kind > 2) ? $urandom_range(2) : kind);
      send_request(r, 1'b0, none);
    end
  endtask

  always @(posedge clk_i) begin
    if (!hold_rsp && $urandom_range(99) >= recv_stall_pct) rsp.ready <= 1'b1;
    else rsp.ready <= 1'b0;
  end

  // The receiver holds off for a long stretch once the pressure phase starts.
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rsp <= 1'b0;
  end

  always @(posedge clk_i) begin
    decision_t want;
    if (rsp.valid && rsp.ready) begin
      if (pending_decisions.size() == 0) begin
        $error("decision with no request outstanding");
        errors++;
      end else begin
        want = pending_decisions.pop_front();
        if (rsp.allowed !== want.allowed) begin
          $error("allowed exp %0h got %0h", want.allowed, rsp.allowed);
          errors++;
        end
        if (rsp.limit_rpm !== want.limit_rpm) begin
          $error("limit_rpm exp %0d got %0d", want.limit_rpm, rsp.limit_rpm);
          errors++;
        end
        if (rsp.remaining !== want.remaining) begin
          $error("remaining exp %0d got %0d", want.remaining, rsp.remaining);
          errors++;
        end
        if (rsp.retry_after_s !== want.retry_after_s) begin
          $error("retry_after_s exp %0d got %0d", want.retry_after_s, rsp.retry_after_s);
          errors++;
        end
        if (rsp.reset_epoch_s !== want.reset_epoch_s) begin
          $error("reset_epoch_s exp %0d got %0d", want.reset_epoch_s, rsp.reset_epoch_s);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  typedef struct {
    request_t  r;
    bit        typed;
    decision_t want;
  } row_t;

  row_t directed [$];

  function automatic row_t row(logic [7:0] s, logic [63:0] rpm, logic [63:0] ms,
                               logic [63:0] wall, bit typed, logic ok,
                               logic [63:0] lim, logic [63:0] rem,
                               logic [63:0] retry, logic [63:0] rst);
    row_t x;
    x.r.client_slot = s;
    x.r.endpoint_rpm = rpm[RATE_W-1:0];
    x.r.now_ms = ms[MS_W-1:0];
    x.r.wall_s = wall[WALL_W-1:0];
    x.typed = typed;
    x.want.allowed = ok;
    x.want.limit_rpm = lim[RATE_W-1:0];
    x.want.remaining = rem[RATE_W-1:0];
    x.want.retry_after_s = retry[5:0];
    x.want.reset_epoch_s = rst[WALL_W:0];
    return x;
  endfunction

  initial begin
    req.valid = 1'b0;
    req.client_slot = '0;
    req.endpoint_rpm = '0;
    req.now_ms = '0;
    req.wall_s = '0;
    global_rate = 600;
    default_rate = 60;
    sweep_s = 300;
    idle_s = 600;
    global_tokens = 600 * UNITS;
    global_last = 0;
    last_sweep = 0;
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed = {directed, row(8'd0, 0, 0, 0, 1, 1, 60, 59, 0, 60)};
    directed = {directed, row(8'd255, 20'hFFFFF, 10, 40'hFF_FFFF_FFFF, 1, 1, 20'hFFFFF,
                              20'hFFFFE, 0, 64'hFF_FFFF_FFFF + 60)};
    directed = {directed, row(8'd1, 1, 20, 5, 1, 1, 1, 0, 0, 65)};
    directed = {directed, row(8'd1, 1, 30, 5, 1, 0, 1, 0, 60, 65)};
    directed = {directed, row(8'd1, 1, 60030, 7, 0, 0, 0, 0, 0, 0)};
    directed = {directed, row(8'd1, 7, 60031, 7, 0, 0, 0, 0, 0, 0)};
    directed = {directed, row(8'd2, 1000, 50, 9, 0, 0, 0, 0, 0, 0)};
    directed = {directed, row(8'd0, 0, 40, 9, 0, 0, 0, 0, 0, 0)};
    directed = {directed, row(8'd3, 5, 48'hFFFF_FFFF_FFFF, 1, 0, 0, 0, 0, 0, 0)};
    directed = {directed, row(8'd3, 5, 100, 1, 0, 0, 0, 0, 0, 0)};
    directed = {directed, row(8'd128, 0, 48'hAAAA_5555_AAAA, 40'h55_AAAA_5555,
                              0, 0, 0, 0, 0, 0)};
    directed = {directed, row(8'd85, 20'h55555, 48'h5555_AAAA_5555, 40'hAA_5555_AAAA,
                              0, 0, 0, 0, 0, 0)};
    foreach (directed[i]) send_request(directed[i].r, directed[i].typed, directed[i].want);
    quiesce();

    // A tiny global bucket drives the global denial path and its retry time.
    write_register(CFG_GLOBAL_RATE, 1);
    write_register(CFG_DEFAULT_RATE, 2);
    write_register(CFG_SWEEP_INTERVAL, 1);
    write_register(CFG_MAX_IDLE, 1);
    clock_ms = 64'h1_0000_0000;
    run_phase(40, 0, 0, 7, 3);
    quiesce();

    // Zero rates: clients that never refill, then a global bucket that never refills.
    write_register(CFG_GLOBAL_RATE, 600);
    write_register(CFG_DEFAULT_RATE, 0);
    run_phase(10, 0, 0, 3, 0);
    quiesce();
    write_register(CFG_GLOBAL_RATE, 0);
    run_phase(4, 0, 0, 3, 3);
    quiesce();

    write_register(CFG_GLOBAL_RATE, 600);
    write_register(CFG_DEFAULT_RATE, 60);
    write_register(CFG_SWEEP_INTERVAL, 300);
    write_register(CFG_MAX_IDLE, 600);
    pressure_go = 1'b1;
    run_phase(290, 0, 0, 255, 3);
    run_phase(290, 46, 0, 255, 3);
    run_phase(290, 0, 46, 255, 3);
    run_phase(290, 22, 22, 255, 3);
    quiesce();

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
